// ----- rtl/brs_pkg.sv -----
// Shared types and constants of the bitmap run search block.
`default_nettype none

package brs_pkg;

  // Fixed field widths.
  localparam int ENTRY_W    = 11;  // entry_count, run_length, start_position
  localparam int POS_W      = 12;  // internal positions, with room for one word past the limit
  localparam int IDX_W      = 4;   // word_index
  localparam int DATA_W     = 64;  // word_data
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Input word kinds, carried on in_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register index (paddr[2]) and reset value.
  localparam logic               REG_ENTRY_COUNT = 1'b0;
  localparam logic [ENTRY_W-1:0] ENTRY_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } brs_state_t;

  typedef struct packed {
    logic clr;       // clear one memory word
    logic wr;        // store the input word
    logic start;     // begin a search with the input fields
    logic out_load;  // move the search result into the output register
  } brs_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass is at its last word
    logic scan_done;  // scan stopped and pipeline drained
  } brs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bitmap_run_search.sv -----
// Top level of the bitmap run search block: ports, configuration register, controller and datapath.
// Writes give no result and may follow back to back. A search scans the words that hold the
// first min(entry_count, WORD_BITS * WORD_COUNT) entries; a hit ends the scan early, and a zero
// run length or entry count ends it before any word is issued. No word is accepted while a search
// runs; once its result has moved to the output register, the next word can be taken.
// Reset (rst_n low, synchronous) clears control state and sets entry_count to 1024; a clearing
// pass then zeroes the bitmap, during which no input word is accepted.
`default_nettype none

module bitmap_run_search
  import brs_pkg::*;
#(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata, from bit 0 up: word_index[3:0], word_data[67:4], want_clear[68],
  // run_length[79:69].
  input  wire logic [79:0]           in_tdata,
  // in_tuser: operation (0 writes a word, 1 searches).
  input  wire logic                  in_tuser,

  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata, from bit 0 up: start_position[10:0], zero padding[15:11].
  output logic [15:0]                out_tdata,
  // out_tuser: found.
  output logic                       out_tuser,

  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // The only register, entry_count, sits at byte address 0. Bit 2 of the
  // address selects the register slot; writes to the empty slot are dropped.
  logic [ENTRY_W-1:0] entry_count_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ENTRY_COUNT)) begin
      entry_count_r <= cfg_pwdata[ENTRY_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ENTRY_COUNT) begin
      cfg_prdata = CFG_DATA_W'(entry_count_r);
    end
  end

  // The controller sequences the clearing pass, accepts words and hands the
  // finished search result to the output register. The datapath holds the
  // bitmap memory and a four-stage scan pipeline: memory read, match vector
  // and run window, per-word features (leading and trailing matches and the
  // first run fully inside the word), and the combine step that carries the
  // open run across word boundaries.
  brs_cmd_t           cmd;
  brs_sts_t           sts;
  logic [ENTRY_W-1:0] out_pos;
  logic               out_found;

  brs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  brs_dpath #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .entry_count (entry_count_r),
    .word_index  (in_tdata[3:0]),
    .word_data   (in_tdata[67:4]),
    .want_clear  (in_tdata[68]),
    .run_length  (in_tdata[79:69]),
    .out_pos     (out_pos),
    .out_found   (out_found)
  );

  assign out_tdata = {5'b0, out_pos};
  assign out_tuser = out_found;

endmodule

`default_nettype wire

// ----- rtl/brs_ctrl.sv -----
// Controller state machine of the bitmap run search block.
`default_nettype none

module brs_ctrl
  import brs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_op,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire brs_sts_t sts,
  output brs_cmd_t      cmd
);

  brs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/brs_dpath.sv -----
// Datapath of the bitmap run search block: bitmap memory and scan pipeline.
`default_nettype none

module brs_dpath
  import brs_pkg::*;
#(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire brs_cmd_t           cmd,
  output brs_sts_t                sts,
  input  wire logic [ENTRY_W-1:0] entry_count,
  input  wire logic [IDX_W-1:0]   word_index,
  input  wire logic [DATA_W-1:0]  word_data,
  input  wire logic               want_clear,
  input  wire logic [ENTRY_W-1:0] run_length,
  output logic      [ENTRY_W-1:0] out_pos,
  output logic                    out_found
);

  localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LOG_W  = $clog2(WORD_BITS);
  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int K_MAX  = $clog2(WORD_BITS + 1) - 1;
  localparam int KS_W   = (K_MAX > 0) ? $clog2(K_MAX + 1) : 1;
  localparam int TOTAL  = WORD_BITS * WORD_COUNT;
  localparam logic [POS_W-1:0] W_POS = POS_W'(WORD_BITS);

  // Search limit: entries beyond storage do not exist.
  logic [ENTRY_W-1:0] limit;
  assign limit = (32'(entry_count) > TOTAL) ? ENTRY_W'(TOTAL) : entry_count;

  // Bitmap memory and clearing pass.
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [ADDR_W-1:0]    iss_addr_r;
  logic                 wr_ok;
  logic [ADDR_W-1:0]    wr_addr;

  assign wr_ok   = 32'(word_index) < WORD_COUNT;
  assign wr_addr = ADDR_W'(word_index);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wr && wr_ok) begin
      mem[wr_addr] <= word_data[WORD_BITS-1:0];
    end
    rd_data_r <= mem[iss_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  assign sts.clr_last = (32'(clr_addr_r) == WORD_COUNT - 1);

  // Search setup. A run of n bits is the AND of two overlapping windows of
  // 2^k bits, with 2^k <= n < 2^(k+1), the second shifted by n - 2^k.
  logic               want_r;
  logic [ENTRY_W-1:0] need_r;
  logic [KS_W-1:0]    ksel_r, ksel_nxt;
  logic [LOG_W-1:0]   dsh_r, dsh_nxt;
  logic               inner_ok_r, inner_ok_nxt;

  always_comb begin
    ksel_nxt = '0;
    for (int k = 0; k <= K_MAX; k++) begin
      if (32'(run_length) >= (32'd1 << k)) begin
        ksel_nxt = KS_W'(k);
      end
    end
    dsh_nxt      = LOG_W'(32'(run_length) - (32'd1 << ksel_nxt));
    inner_ok_nxt = (run_length != '0) && (32'(run_length) <= WORD_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      want_r     <= want_clear;
      need_r     <= run_length;
      ksel_r     <= ksel_nxt;
      dsh_r      <= dsh_nxt;
      inner_ok_r <= inner_ok_nxt;
    end
  end

  // Word issue.
  logic                 iss_on_r;
  logic [POS_W-1:0]     iss_base_r;
  logic [POS_W-1:0]     base_step;
  logic [POS_W-1:0]     rem;
  logic [WORD_BITS-1:0] mask_nxt;
  logic                 issuing;
  logic                 hit_r;

  assign issuing   = iss_on_r && !hit_r;
  assign base_step = iss_base_r + W_POS;
  assign rem       = POS_W'(limit) - iss_base_r;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask_nxt[b] = POS_W'(b) < rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_on_r <= 1'b0;
    end else if (cmd.start) begin
      iss_on_r <= (run_length != '0) && (limit != '0);
    end else if (hit_r || (iss_on_r && base_step >= POS_W'(limit))) begin
      iss_on_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      iss_addr_r <= '0;
      iss_base_r <= '0;
    end else if (issuing) begin
      iss_addr_r <= iss_addr_r + ADDR_W'(1);
      iss_base_r <= base_step;
    end
  end

  // Stage A: read data arrives; build match vector and the 2^k window.
  logic                 a_vld_r;
  logic [POS_W-1:0]     a_base_r;
  logic [WORD_BITS-1:0] a_mask_r;
  logic [WORD_BITS-1:0] m_a;
  logic [WORD_BITS-1:0] pk [K_MAX+1];

  always_ff @(posedge clk) begin
    if (issuing) begin
      a_base_r <= iss_base_r;
      a_mask_r <= mask_nxt;
    end
  end

  always_comb begin
    m_a   = (rd_data_r ^ {WORD_BITS{want_r}}) & a_mask_r;
    pk[0] = m_a;
    for (int k = 1; k <= K_MAX; k++) begin
      pk[k] = pk[k-1] & (pk[k-1] >> (1 << (k - 1)));
    end
  end

  // Stage B: word features.
  logic                 b_vld_r;
  logic [POS_W-1:0]     b_base_r;
  logic [WORD_BITS-1:0] b_m_r;
  logic [WORD_BITS-1:0] b_pk_r;
  logic [WORD_BITS-1:0] win;
  logic [LOG_W-1:0]     ipos_b;
  logic [CNT_W-1:0]     t0_b;
  logic [CNT_W-1:0]     h_b;

  always_ff @(posedge clk) begin
    b_base_r <= a_base_r;
    b_m_r    <= m_a;
    b_pk_r   <= pk[ksel_r];
  end

  always_comb begin
    win    = b_pk_r & (b_pk_r >> dsh_r);
    ipos_b = '0;
    t0_b   = CNT_W'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (win[b]) begin
        ipos_b = LOG_W'(b);
      end
      if (!b_m_r[b]) begin
        t0_b = CNT_W'(b);
      end
    end
    h_b = CNT_W'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!b_m_r[b]) begin
        h_b = CNT_W'(WORD_BITS - 1 - b);
      end
    end
  end

  // Stage C: combine features with the run carried from earlier words.
  logic               c_vld_r;
  logic [POS_W-1:0]   c_base_r;
  logic [CNT_W-1:0]   c_t0_r;
  logic [CNT_W-1:0]   c_h_r;
  logic               c_all_r;
  logic               c_ihit_r;
  logic [LOG_W-1:0]   c_ipos_r;

  always_ff @(posedge clk) begin
    c_base_r <= b_base_r;
    c_t0_r   <= t0_b;
    c_h_r    <= h_b;
    c_all_r  <= &b_m_r;
    c_ihit_r <= inner_ok_r && (|win);
    c_ipos_r <= ipos_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= issuing;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  logic [POS_W-1:0]   carry_r;
  logic [POS_W-1:0]   seg_r;
  logic [ENTRY_W-1:0] res_pos_r;
  logic               res_found_r;
  logic [POS_W-1:0]   sum;
  logic [POS_W-1:0]   seg;
  logic               take;
  logic               hit_lead;
  logic               hit_inner;

  assign sum       = carry_r + POS_W'(c_t0_r);
  assign seg       = (carry_r == '0) ? c_base_r : seg_r;
  assign take      = c_vld_r && !hit_r;
  assign hit_lead  = sum >= POS_W'(need_r);
  assign hit_inner = !c_all_r && c_ihit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.start) begin
      hit_r <= 1'b0;
    end else if (take && (hit_lead || hit_inner)) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      carry_r     <= '0;
      seg_r       <= '0;
      res_pos_r   <= entry_count;
      res_found_r <= 1'b0;
    end else if (take) begin
      if (hit_lead) begin
        res_pos_r   <= ENTRY_W'(seg);
        res_found_r <= 1'b1;
      end else if (hit_inner) begin
        res_pos_r   <= ENTRY_W'(c_base_r + POS_W'(c_ipos_r));
        res_found_r <= 1'b1;
      end else if (c_all_r) begin
        carry_r <= sum;
        seg_r   <= seg;
      end else begin
        carry_r <= POS_W'(c_h_r);
        seg_r   <= c_base_r + W_POS - POS_W'(c_h_r);
      end
    end
  end

  assign sts.scan_done = !iss_on_r && !a_vld_r && !b_vld_r && !c_vld_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos   <= res_pos_r;
      out_found <= res_found_r;
    end
  end

endmodule

`default_nettype wire
